// ----- design/xte_pkg.sv -----
// ----------------------------------------------------------------------------
// xte_pkg
// Types and constants shared by the XML text escaper with UTF-8 output.
// ----------------------------------------------------------------------------
`default_nettype none

package xte_pkg;

    localparam int CP_W      = 21;
    localparam int SEQ_BYTES = 6;
    localparam int CNT_W     = 3;

    typedef logic [SEQ_BYTES-1:0][7:0] seq_t;

    // Byte sequence for one character, byte 0 goes out first.
    typedef struct packed {
        seq_t             bytes;
        logic [CNT_W-1:0] cnt;
        logic             byte_valid;
        logic             last;
    } enc_t;

    localparam logic [CP_W-1:0] CP_TAB       = 21'h00009;
    localparam logic [CP_W-1:0] CP_LF        = 21'h0000A;
    localparam logic [CP_W-1:0] CP_VT        = 21'h0000B;
    localparam logic [CP_W-1:0] CP_FF        = 21'h0000C;
    localparam logic [CP_W-1:0] CP_AMP       = 21'h00026;
    localparam logic [CP_W-1:0] CP_LT        = 21'h0003C;
    localparam logic [CP_W-1:0] CP_GT        = 21'h0003E;
    localparam logic [CP_W-1:0] CP_CTRL_LIM  = 21'h00020;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_REPLACE   = 21'h0FFFD;
    localparam logic [CP_W-1:0] CP_LIM_1B    = 21'h00080;
    localparam logic [CP_W-1:0] CP_LIM_2B    = 21'h00800;
    localparam logic [CP_W-1:0] CP_LIM_3B    = 21'h10000;

    localparam seq_t ESC_LT  = 48'h0000_3b74_6c26; // &lt;
    localparam seq_t ESC_GT  = 48'h0000_3b74_6726; // &gt;
    localparam seq_t ESC_AMP = 48'h003b_706d_6126; // &amp;
    localparam seq_t ESC_BR  = 48'h003e_2f72_623c; // <br/>
    localparam seq_t ESC_CBR = 48'h3e2f_7262_633c; // <cbr/>
    localparam seq_t ESC_PBR = 48'h3e2f_7262_703c; // <pbr/>

endpackage

`default_nettype wire

// ----- design/xml_text_escape_utf8_top.sv -----
// ----------------------------------------------------------------------------
// xml_text_escape_utf8_top
// XML text escaper: one Unicode code point in, escaped UTF-8 bytes out.
//
// Input channel (cp_valid/cp_ready) takes one word per character:
// code_point and last_char. Output channel (res_valid/res_ready) gives one
// word per byte: out_byte, byte_valid, char_done, string_end.
// A character yields 1 to 6 output words (escapes up to 6 bytes, UTF-8 up
// to 4). A dropped control character yields none, or a single end marker
// with byte_valid 0 when it closes the string.
// An accepted character goes into the character buffer; its bytes move one
// at a time from there into the byte-wide output register, and the next
// character is taken in the cycle its last byte moves to the output
// register. Dropped characters that give nothing are accepted without
// entering the character buffer.
// Reset clears the valid flags of the character buffer and the output
// register. When the receiver stalls, the output word holds and cp_ready
// drops once the buffered character has no room to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_text_escape_utf8_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cp_valid,
    output logic             cp_ready,
    input  wire logic [20:0] code_point,
    input  wire logic        last_char,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             char_done,
    output logic             string_end
);

    xte_pkg::enc_t enc;

    xte_encoder u_encoder (
        .code_point (code_point),
        .last_char  (last_char),
        .enc        (enc)
    );

    xte_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (cp_valid),
        .load_ready (cp_ready),
        .enc        (enc),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .char_done  (char_done),
        .string_end (string_end)
    );

endmodule

`default_nettype wire

// ----- design/xte_encoder.sv -----
// ----------------------------------------------------------------------------
// xte_encoder
// Maps one code point to its escaped UTF-8 byte sequence and length.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_encoder (
    input  wire logic [xte_pkg::CP_W-1:0] code_point,
    input  wire logic                     last_char,
    output xte_pkg::enc_t                 enc
);

    logic [xte_pkg::CP_W-1:0] cp_s;

    always_comb
    begin
        if ((code_point inside {[xte_pkg::CP_SURR_LO:xte_pkg::CP_SURR_HI]}) ||
            code_point > xte_pkg::CP_MAX)
        begin
            cp_s = xte_pkg::CP_REPLACE;
        end
        else
        begin
            cp_s = code_point;
        end
    end

    always_comb
    begin
        enc            = '0;
        enc.last       = last_char;
        enc.byte_valid = 1'b1;
        case (code_point)
            xte_pkg::CP_LT:
            begin
                enc.bytes = xte_pkg::ESC_LT;
                enc.cnt   = 3'd4;
            end
            xte_pkg::CP_GT:
            begin
                enc.bytes = xte_pkg::ESC_GT;
                enc.cnt   = 3'd4;
            end
            xte_pkg::CP_AMP:
            begin
                enc.bytes = xte_pkg::ESC_AMP;
                enc.cnt   = 3'd5;
            end
            xte_pkg::CP_LF:
            begin
                enc.bytes = xte_pkg::ESC_BR;
                enc.cnt   = 3'd5;
            end
            xte_pkg::CP_VT:
            begin
                enc.bytes = xte_pkg::ESC_CBR;
                enc.cnt   = 3'd6;
            end
            xte_pkg::CP_FF:
            begin
                enc.bytes = xte_pkg::ESC_PBR;
                enc.cnt   = 3'd6;
            end
            xte_pkg::CP_TAB:
            begin
                enc.bytes[0] = code_point[7:0];
                enc.cnt      = 3'd1;
            end
            default:
            begin
                if (code_point < xte_pkg::CP_CTRL_LIM)
                begin
                    // dropped control: end marker only if it closes the string
                    enc.byte_valid = 1'b0;
                    enc.cnt        = last_char ? 3'd1 : 3'd0;
                end
                else if (cp_s < xte_pkg::CP_LIM_1B)
                begin
                    enc.bytes[0] = cp_s[7:0];
                    enc.cnt      = 3'd1;
                end
                else if (cp_s < xte_pkg::CP_LIM_2B)
                begin
                    enc.bytes[0] = {3'b110, cp_s[10:6]};
                    enc.bytes[1] = {2'b10, cp_s[5:0]};
                    enc.cnt      = 3'd2;
                end
                else if (cp_s < xte_pkg::CP_LIM_3B)
                begin
                    enc.bytes[0] = {4'b1110, cp_s[15:12]};
                    enc.bytes[1] = {2'b10, cp_s[11:6]};
                    enc.bytes[2] = {2'b10, cp_s[5:0]};
                    enc.cnt      = 3'd3;
                end
                else
                begin
                    enc.bytes[0] = {5'b11110, cp_s[20:18]};
                    enc.bytes[1] = {2'b10, cp_s[17:12]};
                    enc.bytes[2] = {2'b10, cp_s[11:6]};
                    enc.bytes[3] = {2'b10, cp_s[5:0]};
                    enc.cnt      = 3'd4;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/xte_serializer.sv -----
// ----------------------------------------------------------------------------
// xte_serializer
// Holds one encoded character and shifts its bytes into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_serializer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load_valid,
    output logic               load_ready,
    input  wire xte_pkg::enc_t enc,
    output logic               res_valid,
    input  wire logic          res_ready,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               char_done,
    output logic               string_end
);

    logic                      buf_valid_reg;
    logic                      buf_valid_next;
    xte_pkg::seq_t             bytes_reg;
    xte_pkg::seq_t             bytes_next;
    logic [xte_pkg::CNT_W-1:0] rem_reg;
    logic [xte_pkg::CNT_W-1:0] rem_next;
    logic                      mark_reg;
    logic                      mark_next;
    logic                      last_reg;
    logic                      last_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [7:0]                out_byte_reg;
    logic                      out_bv_reg;
    logic                      out_done_reg;
    logic                      out_end_reg;

    logic                      out_free;
    logic                      emit;
    logic                      final_byte;
    logic                      load;

    assign out_free   = !out_valid_reg || res_ready;
    assign emit       = buf_valid_reg && out_free;
    assign final_byte = rem_reg == xte_pkg::CNT_W'(1);
    assign load_ready = !buf_valid_reg || (emit && final_byte);
    assign load       = load_valid && load_ready && (enc.cnt != '0);

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        bytes_next     = bytes_reg;
        rem_next       = rem_reg;
        mark_next      = mark_reg;
        last_next      = last_reg;
        if (load)
        begin
            buf_valid_next = 1'b1;
            bytes_next     = enc.bytes;
            rem_next       = enc.cnt;
            mark_next      = enc.byte_valid;
            last_next      = enc.last;
        end
        else if (emit)
        begin
            buf_valid_next = !final_byte;
            bytes_next     = bytes_reg >> 8;
            rem_next       = rem_reg - xte_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        rem_reg   <= rem_next;
        mark_reg  <= mark_next;
        last_reg  <= last_next;
        if (emit)
        begin
            out_byte_reg <= bytes_reg[0];
            out_bv_reg   <= mark_reg;
            out_done_reg <= final_byte;
            out_end_reg  <= final_byte && last_reg;
        end
    end

    assign res_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = out_bv_reg;
    assign char_done  = out_done_reg;
    assign string_end = out_end_reg;

    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> rem_reg != '0)
        else $error("held character has no bytes left");

    a_mark_single: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg && !mark_reg |-> rem_reg == xte_pkg::CNT_W'(1) && last_reg)
        else $error("end marker is not a single closing result");

    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_bv_reg |-> out_done_reg && out_end_reg)
        else $error("end marker without string end");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_done_reg)
        else $error("string end before character done");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xml_text_escape_utf8_top. Characters are sent on
// the input channel with random gaps; each accepted one is run through an
// escaper/UTF-8 encoder in the bench, and every output word is compared in
// order against that prediction. Directed corners come first, then random
// strings under three idle patterns.
// ----------------------------------------------------------------------------

module tb;

    typedef struct packed {
        logic [7:0] octet;
        logic       has_byte;
        logic       chr_done;
        logic       str_end;
    } esc_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cp_valid = 1'b0;
    logic                     cp_ready;
    logic [xte_pkg::CP_W-1:0] code_point = '0;
    logic                     last_char = 1'b0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    logic [7:0]               out_byte;
    logic                     byte_valid;
    logic                     char_done;
    logic                     string_end;

    esc_word_t escaped_q[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    xml_text_escape_utf8_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .code_point (code_point),
        .last_char  (last_char),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .char_done  (char_done),
        .string_end (string_end)
    );

    always #5 clk = ~clk;

    // Expected output words for one character.
    function automatic void escape_char(logic [xte_pkg::CP_W-1:0] cp, logic lc);
        string                    esc;
        logic [7:0]               seq[$];
        logic [xte_pkg::CP_W-1:0] v;
        esc_word_t                w;
        esc = "";
        case (cp)
            xte_pkg::CP_LT:  esc = "&lt;";
            xte_pkg::CP_GT:  esc = "&gt;";
            xte_pkg::CP_AMP: esc = "&amp;";
            xte_pkg::CP_LF:  esc = "<br/>";
            xte_pkg::CP_VT:  esc = "<cbr/>";
            xte_pkg::CP_FF:  esc = "<pbr/>";
            default:         esc = "";
        endcase
        if (esc.len() != 0)
        begin
            for (int i = 0; i < esc.len(); i++)
                seq.push_back(esc[i]);
        end
        else if (cp == xte_pkg::CP_TAB)
        begin
            seq.push_back(8'h09);
        end
        else if (cp >= xte_pkg::CP_CTRL_LIM)
        begin
            if ((cp >= xte_pkg::CP_SURR_LO && cp <= xte_pkg::CP_SURR_HI) ||
                cp > xte_pkg::CP_MAX)
                v = xte_pkg::CP_REPLACE;
            else
                v = cp;
            if (v < xte_pkg::CP_LIM_1B)
            begin
                seq.push_back(v[7:0]);
            end
            else if (v < xte_pkg::CP_LIM_2B)
            begin
                seq.push_back({3'b110, v[10:6]});
                seq.push_back({2'b10, v[5:0]});
            end
            else if (v < xte_pkg::CP_LIM_3B)
            begin
                seq.push_back({4'b1110, v[15:12]});
                seq.push_back({2'b10, v[11:6]});
                seq.push_back({2'b10, v[5:0]});
            end
            else
            begin
                seq.push_back({5'b11110, v[20:18]});
                seq.push_back({2'b10, v[17:12]});
                seq.push_back({2'b10, v[11:6]});
                seq.push_back({2'b10, v[5:0]});
            end
        end
        if (seq.size() == 0)
        begin
            if (lc)
                escaped_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
        end
        else
        begin
            for (int i = 0; i < seq.size(); i++)
            begin
                w.octet    = seq[i];
                w.has_byte = 1'b1;
                w.chr_done = (i == seq.size() - 1);
                w.str_end  = (i == seq.size() - 1) && lc;
                escaped_q.push_back(w);
            end
        end
    endfunction

    task automatic send_char(input logic [xte_pkg::CP_W-1:0] cp, input logic lc);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cp_valid <= 1'b0;
            @(posedge clk);
        end
        cp_valid   <= 1'b1;
        code_point <= cp;
        last_char  <= lc;
        do
            @(posedge clk);
        while (!cp_ready);
        escape_char(cp, lc);
    endtask

    function automatic logic [xte_pkg::CP_W-1:0] rand_code_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return xte_pkg::CP_W'($urandom_range(32'h20, 32'h7E));
        if (r < 40)
        begin
            case ($urandom_range(0, 2))
                0:       return xte_pkg::CP_LT;
                1:       return xte_pkg::CP_GT;
                default: return xte_pkg::CP_AMP;
            endcase
        end
        if (r < 50)
            return xte_pkg::CP_W'($urandom_range(0, 32'h1F));
        if (r < 52)
            return xte_pkg::CP_W'(32'h7F);
        if (r < 65)
            return xte_pkg::CP_W'($urandom_range(32'h80, 32'h7FF));
        if (r < 78)
            return xte_pkg::CP_W'($urandom_range(32'h800, 32'hFFFF));
        if (r < 83)
            return xte_pkg::CP_W'($urandom_range(32'hD800, 32'hDFFF));
        if (r < 93)
            return xte_pkg::CP_W'($urandom_range(32'h10000, 32'h10FFFF));
        return xte_pkg::CP_W'($urandom_range(32'h110000, 32'h1FFFFF));
    endfunction

    task automatic test_escapes();
        send_char(xte_pkg::CP_LT, 1'b0);
        send_char(xte_pkg::CP_GT, 1'b0);
        send_char(xte_pkg::CP_AMP, 1'b0);
        send_char(xte_pkg::CP_LF, 1'b0);
        send_char(xte_pkg::CP_VT, 1'b0);
        send_char(xte_pkg::CP_FF, 1'b1);
    endtask

    task automatic test_controls();
        send_char(xte_pkg::CP_TAB, 1'b0);
        send_char(xte_pkg::CP_W'(0), 1'b0);
        send_char(xte_pkg::CP_W'(32'h0D), 1'b0);
        send_char(xte_pkg::CP_W'(32'h1F), 1'b1);
        send_char(xte_pkg::CP_W'(0), 1'b1);
        send_char(xte_pkg::CP_TAB, 1'b1);
    endtask

    task automatic test_utf8_ranges();
        send_char(xte_pkg::CP_CTRL_LIM, 1'b0);
        send_char(xte_pkg::CP_W'(32'h7F), 1'b0);
        send_char(xte_pkg::CP_LIM_1B, 1'b0);
        send_char(xte_pkg::CP_W'(32'h7FF), 1'b0);
        send_char(xte_pkg::CP_LIM_2B, 1'b0);
        send_char(xte_pkg::CP_W'(32'hFFFF), 1'b0);
        send_char(xte_pkg::CP_LIM_3B, 1'b0);
        send_char(xte_pkg::CP_MAX, 1'b1);
    endtask

    task automatic test_invalid_points();
        send_char(xte_pkg::CP_SURR_LO, 1'b0);
        send_char(xte_pkg::CP_SURR_HI, 1'b0);
        send_char(xte_pkg::CP_W'(32'h110000), 1'b0);
        send_char(xte_pkg::CP_W'(32'h1FFFFF), 1'b1);
    endtask

    // Random strings; mostly terminated, with some stray last_char marks.
    task automatic test_random(input int n_chars);
        int sent;
        int len;
        sent = 0;
        while (sent < n_chars)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len && sent < n_chars; i++)
            begin
                send_char(rand_code_point(),
                          (i == len - 1) || ($urandom_range(0, 19) == 0));
                sent++;
            end
        end
    endtask

    always @(posedge clk)
        res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        esc_word_t got;
        esc_word_t want;
        if (rst_n && res_valid && res_ready)
        begin
            got = '{out_byte, byte_valid, char_done, string_end};
            if (escaped_q.size() == 0)
            begin
                $display("%0t: unexpected word byte=%02h bv=%0b cd=%0b se=%0b",
                         $time, got.octet, got.has_byte, got.chr_done, got.str_end);
                mismatches++;
            end
            else
            begin
                want = escaped_q.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: expected byte=%02h bv=%0b cd=%0b se=%0b,",
                              " got byte=%02h bv=%0b cd=%0b se=%0b"},
                             $time, want.octet, want.has_byte, want.chr_done,
                             want.str_end, got.octet, got.has_byte, got.chr_done,
                             got.str_end);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 88;
        test_escapes();
        test_controls();
        test_utf8_ranges();
        test_invalid_points();
        test_random(112);

        send_idle_pct = 88;
        recv_idle_pct = 13;
        test_random(112);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(112);

        cp_valid <= 1'b0;
        while (escaped_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && escaped_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- xml_text_escape_utf8_top.f -----
design/xte_pkg.sv
design/xte_encoder.sv
design/xte_serializer.sv
design/xml_text_escape_utf8_top.sv
tb/tb.sv
